// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the record exchange sorter checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RXS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rxs assertion failed");

// checked on every edge, reset included
`define RXS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rxs assertion failed");

`endif

// File: hdl/rxs_pkg.sv
// ---------------------------------------------------------------------------
// rxs_pkg
// record and beat types shared by the record exchange sorter modules
// ---------------------------------------------------------------------------
package rxs_pkg;

  typedef struct packed {
    logic [15:0] area;
    logic [7:0]  energy_class;
    logic [31:0] cost;
  } in_rec_t;

  typedef struct packed {
    logic [15:0] out_area;
    logic [7:0]  out_class;
    logic [31:0] out_cost;
    logic        last_out;
  } out_rec_t;

  // load beat from front to back, tagged with end of batch
  typedef struct packed {
    in_rec_t rec;
    logic    last;
  } ld_beat_t;

  localparam int unsigned MODE_W = 2;

  typedef logic [MODE_W-1:0] mode_t;

  // sort mode codes, the unused code runs both passes
  localparam mode_t MODE_AREA       = 2'd0;
  localparam mode_t MODE_CLASS_AREA = 2'd1;
  localparam mode_t MODE_BOTH       = 2'd2;
  localparam mode_t MODE_UNUSED     = 2'd3;

endpackage

// File: hdl/record_exchange_sorter.sv
// ---------------------------------------------------------------------------
// record_exchange_sorter
// loads a batch of records, sorts it in place by the selected key and
// emits the sorted batch with the final record marked
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         push / full        in_data  (area, energy_class, cost)
// result    out        empty / pop        out_data (out_area, out_class,
//                                                   out_cost, last_out)
// config    in         cfg_we             cfg_data (sort_mode)
//
// load: one beat per cycle while the two beat front queue is not full
// sort: one or two passes, paced by the single read and single write port
//   of the store
// emit: a read state and a wait state per record, a held result stalls the sequencer
// reset clears control only, the record store needs no clearing pass
// ---------------------------------------------------------------------------
module record_exchange_sorter #(
  parameter int unsigned RECORDS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rxs_pkg::in_rec_t           in_data,
  output logic                       full,
  output logic                       empty,
  output rxs_pkg::out_rec_t          out_data,
  input  logic                       pop,
  input  logic                       cfg_we,
  input  logic [rxs_pkg::MODE_W-1:0] cfg_data
);

  logic [rxs_pkg::MODE_W-1:0] mode_r;
  logic                       q_push;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  rxs_pkg::ld_beat_t          q_in;
  rxs_pkg::ld_beat_t          q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  rxs_front #(
    .RECORDS (RECORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (q_push),
    .q_beat  (q_in),
    .q_full  (q_full)
  );

  rxs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_beat (q_in),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_beat (q_out),
    .rd_en   (q_pop)
  );

  rxs_back #(
    .RECORDS (RECORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sort_mode (mode_r),
    .q_valid   (q_valid),
    .q_beat    (q_out),
    .q_pop     (q_pop),
    .empty     (empty),
    .out_data  (out_data),
    .pop       (pop)
  );

endmodule

// File: hdl/rxs_front.sv
// ---------------------------------------------------------------------------
// rxs_front
// accepts input beats, counts the batch and tags the final record
// ---------------------------------------------------------------------------
module rxs_front #(
  parameter int unsigned RECORDS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rxs_pkg::in_rec_t  in_data,
  output logic              full,
  output logic              q_push,
  output rxs_pkg::ld_beat_t q_beat,
  input  logic              q_full
);

  localparam int unsigned AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RECORDS - 1);
  localparam logic [AW-1:0] ONE = AW'(1);

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;
  logic          is_last;

  assign full     = q_full;
  assign q_push   = push & ~q_full;
  assign is_last  = (cnt_r == LAST_IDX);
  assign q_beat.rec  = in_data;
  assign q_beat.last = is_last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = is_last ? '0 : cnt_r + ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/rxs_queue.sv
// ---------------------------------------------------------------------------
// rxs_queue
// two entry queue that decouples the load front from the sort back
// ---------------------------------------------------------------------------
module rxs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  rxs_pkg::ld_beat_t wr_beat,
  output logic              q_full,
  output logic              q_valid,
  output rxs_pkg::ld_beat_t rd_beat,
  input  logic              rd_en
);

  rxs_pkg::ld_beat_t ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign rd_beat = ent_r[rp_r];
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= ~wp_r;
      end
      if (do_rd) begin
        rp_r <= ~rp_r;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/rxs_back.sv
// ---------------------------------------------------------------------------
// rxs_back
// record store, exchange sort sequencer and result register
// ---------------------------------------------------------------------------
module rxs_back #(
  parameter int unsigned RECORDS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rxs_pkg::MODE_W-1:0] sort_mode,
  input  logic                       q_valid,
  input  rxs_pkg::ld_beat_t          q_beat,
  output logic                       q_pop,
  output logic                       empty,
  output rxs_pkg::out_rec_t          out_data,
  input  logic                       pop
);

  localparam int unsigned AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RECORDS - 1);
  localparam logic [AW-1:0] PEN_IDX  = AW'(RECORDS - 2);
  localparam logic [AW-1:0] ONE      = AW'(1);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_ROW_RD    = 3'd1;
  localparam logic [2:0] ST_ROW_CAP   = 3'd2;
  localparam logic [2:0] ST_CMP       = 3'd3;
  localparam logic [2:0] ST_ROW_WR    = 3'd4;
  localparam logic [2:0] ST_EMIT_RD   = 3'd5;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

  localparam logic PASS_AREA  = 1'b0;
  localparam logic PASS_CLASS = 1'b1;

  function automatic logic swap_fn(input logic pass, input rxs_pkg::in_rec_t p,
                                   input rxs_pkg::in_rec_t q);
    logic res;
    if (pass == PASS_CLASS) begin
      res = (p.energy_class > q.energy_class) ||
            ((p.energy_class == q.energy_class) && (p.area < q.area));
    end else begin
      res = (p.area < q.area);
    end
    return res;
  endfunction

  rxs_pkg::in_rec_t  store_r [RECORDS];
  rxs_pkg::in_rec_t  rd_data_r;
  rxs_pkg::in_rec_t  cur_r;
  rxs_pkg::in_rec_t  cur_nxt;
  rxs_pkg::in_rec_t  wr_data;
  rxs_pkg::out_rec_t out_r;
  rxs_pkg::out_rec_t out_nxt;

  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  logic [AW-1:0] ld_cnt_r;
  logic [AW-1:0] ld_cnt_nxt;
  logic [AW-1:0] i_r;
  logic [AW-1:0] i_nxt;
  logic [AW-1:0] j_r;
  logic [AW-1:0] j_nxt;
  logic          pass_r;
  logic          pass_nxt;
  logic          out_vld_r;
  logic          out_vld_nxt;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          do_swap;
  logic          out_free;

  assign empty    = ~out_vld_r;
  assign out_data = out_r;
  assign do_swap  = swap_fn(pass_r, cur_r, rd_data_r);
  assign out_free = ~out_vld_r | pop;

  always_comb begin
    state_nxt   = state_r;
    ld_cnt_nxt  = ld_cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    pass_nxt    = pass_r;
    cur_nxt     = cur_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~pop;
    rd_en       = 1'b0;
    rd_addr     = j_r;
    wr_en       = 1'b0;
    wr_addr     = j_r;
    wr_data     = cur_r;
    q_pop       = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        q_pop = q_valid;
        if (q_valid) begin
          wr_en   = 1'b1;
          wr_addr = ld_cnt_r;
          wr_data = q_beat.rec;
          if (q_beat.last) begin
            ld_cnt_nxt = '0;
            i_nxt      = '0;
            pass_nxt   = (sort_mode == rxs_pkg::MODE_CLASS_AREA) ? PASS_CLASS : PASS_AREA;
            state_nxt  = ST_ROW_RD;
          end else begin
            ld_cnt_nxt = ld_cnt_r + ONE;
          end
        end
      end
      ST_ROW_RD: begin
        rd_en     = 1'b1;
        rd_addr   = i_r;
        state_nxt = ST_ROW_CAP;
      end
      ST_ROW_CAP: begin
        cur_nxt   = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = i_r + ONE;
        j_nxt     = i_r + ONE;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (do_swap) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = cur_r;
          cur_nxt = rd_data_r;
        end
        if (j_r == LAST_IDX) begin
          state_nxt = ST_ROW_WR;
        end else begin
          j_nxt   = j_r + ONE;
          rd_en   = 1'b1;
          rd_addr = j_r + ONE;
        end
      end
      ST_ROW_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = cur_r;
        if (i_r == PEN_IDX) begin
          if ((pass_r == PASS_AREA) && (sort_mode != rxs_pkg::MODE_AREA)) begin
            pass_nxt  = PASS_CLASS;
            i_nxt     = '0;
            state_nxt = ST_ROW_RD;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_EMIT_RD;
          end
        end else begin
          i_nxt     = i_r + ONE;
          rd_en     = 1'b1;
          rd_addr   = i_r + ONE;
          state_nxt = ST_ROW_CAP;
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = j_r;
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          out_nxt.out_area  = rd_data_r.area;
          out_nxt.out_class = rd_data_r.energy_class;
          out_nxt.out_cost  = rd_data_r.cost;
          out_nxt.last_out  = (j_r == LAST_IDX);
          out_vld_nxt       = 1'b1;
          if (j_r == LAST_IDX) begin
            state_nxt = ST_LOAD;
          end else begin
            j_nxt     = j_r + ONE;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      ld_cnt_r  <= '0;
      i_r       <= '0;
      j_r       <= '0;
      pass_r    <= PASS_AREA;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ld_cnt_r  <= ld_cnt_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      pass_r    <= pass_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: hdl/rxs_checker.sv
// ---------------------------------------------------------------------------
// rxs_checker
// port level checks on the record exchange sorter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rxs_checker #(
  parameter int unsigned RECORDS = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input rxs_pkg::out_rec_t out_data
);

  localparam int unsigned AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RECORDS - 1);

  logic          in_beat;
  logic          out_beat;
  logic [15:0]   pend_r;
  logic [AW-1:0] pos_r;

  assign in_beat  = push & ~full;
  assign out_beat = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pos_r  <= '0;
    end else begin
      pend_r <= pend_r + {15'd0, in_beat} - {15'd0, out_beat};
      if (out_beat) begin
        pos_r <= (pos_r == LAST_IDX) ? '0 : pos_r + AW'(1);
      end
    end
  end

  // no result visible straight out of reset
  `RXS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> empty)

  // a waiting result holds until taken
  `RXS_ASSERT(a_out_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_data)))

  // last marker only on the final position of a batch
  `RXS_ASSERT(a_last_pos, clk, rst_n, out_beat |-> (out_data.last_out == (pos_r == LAST_IDX)))

  // every result is backed by the rest of its batch already loaded
  `RXS_ASSERT(a_backlog, clk, rst_n, out_beat |-> (pend_r >= (16'(RECORDS) - 16'(pos_r))))

endmodule

bind record_exchange_sorter rxs_checker #(
  .RECORDS (RECORDS)
) u_rxs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
